@@ hw/rtl/bbf_pkg.sv @@
// ----------------------------------------------------------------------------
// bbf_pkg
// Shared types and constants for the RGB box blur filter.
// ----------------------------------------------------------------------------
package bbf_pkg;

   // reciprocal of the window area, ceil(2^RecipShift / (2r+1)^2), exact for
   // floor division of any window sum up to radius 15
   localparam int RecipShift = 28;
   localparam int RecipW     = 29;

   typedef logic [RecipW-1:0] recip_type;

   localparam recip_type RECIP_TABLE [16] = '{
      29'd268435456, 29'd29826162, 29'd10737419, 29'd5478275,
      29'd3314018,   29'd2218475,  29'd1588376,  29'd1193047,
      29'd928843,    29'd743589,   29'd608698,   29'd507440,
      29'd429497,    29'd368225,   29'd319187,   29'd279330
   };

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } pixel_type;

   // per-item control from the sequencer to the window datapath
   typedef struct packed {
      logic row_zero;   // first row of the frame, column sum starts fresh
      logic row_full;   // a full span of rows is stored, drop the oldest
      logic col_zero;   // first column of the row, window total starts fresh
      logic col_full;   // a full span of columns is held, drop the oldest
   } win_ctrl_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CALC,
      ST_MUL,
      ST_EMIT
   } state_type;

   localparam logic CSR_PADDED_WIDTH  = 1'b0;
   localparam logic CSR_WINDOW_RADIUS = 1'b1;

endpackage

@@ hw/rtl/rgb_box_blur_filter.sv @@
// ----------------------------------------------------------------------------
// rgb_box_blur_filter
// Box (mean) blur over a border-padded RGB raster stream.
// ----------------------------------------------------------------------------
// Pixels of the padded frame enter on req_* in raster order; req_tuser marks
// the first pixel of a frame. Once a pixel completes a (2r+1) square window
// ending at its row and column, one mean pixel leaves on rsp_*, with rsp_tlast
// on the last result of each output row. Other pixels give no result.
// The csr_* port writes padded_width (index 0) and window_radius (index 1);
// any write restarts the frame position. Write only while the block is idle.
// Each pixel passes four steps: accept/memory read, column and window update
// with column sum write back, reciprocal multiply, result load. No new pixel
// is taken until the last has left its load step; the line store and column
// sum RAMs each see one access pattern per pixel; the load sets rsp_tvalid.
// A held result waits in the output register; while rsp_tready stays low
// with a result pending, the next pixel holds the block in its load step.
// Reset (synchronous) restores the default width 642 and radius 1, clears
// the position and drops any pending result. RAM contents are not cleared:
// a read value is used only once its entry is written in the current frame.
// ----------------------------------------------------------------------------
module rgb_box_blur_filter import bbf_pkg::*; #(
   parameter int MAX_RADIUS       = 7,
   parameter int MAX_PADDED_WIDTH = 2048
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // in_blue, in_green, in_red
   input  logic        req_tuser,   // frame_start
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // out_blue, out_green, out_red
   output logic        rsp_tlast,   // out_row_end
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [11:0] csr_data
);

   localparam int SpanMax = 2*MAX_RADIUS + 1;
   localparam int Ring    = SpanMax;
   localparam int SlotW   = $clog2(Ring);
   localparam int SpanW   = $clog2(SpanMax + 1);
   localparam int ColAW   = $clog2(MAX_PADDED_WIDTH);
   localparam int WidW    = $clog2(MAX_PADDED_WIDTH + 1);
   localparam int RadW    = $clog2(MAX_RADIUS + 1);
   localparam int ColW    = $clog2(255*SpanMax + 1);
   localparam int TotW    = $clog2(255*SpanMax*SpanMax + 1);
   localparam int ProdW   = TotW + RecipW;

   state_type        state_ff, state_in;
   logic [11:0]      width_cfg_ff;
   logic [2:0]       radius_cfg_ff;
   logic [ColAW-1:0] col_ff;
   logic [SpanW-1:0] row_ff;
   logic [SlotW-1:0] slot_ff;

   logic [WidW-1:0]  width_eff;
   logic [RadW-1:0]  radius;
   logic [SpanW-1:0] span;
   logic [SpanW-1:0] two_r;

   logic             accept, csr_wr, calc_en, mul_en, emit_go;
   logic [ColAW-1:0] col_a;
   logic [SpanW-1:0] row_a;
   logic [SlotW-1:0] slot_a;
   logic [SlotW-1:0] leave_slot;
   logic [SpanW:0]   slot_x;

   win_ctrl_type     ctrl_ff;
   logic             produce_ff, row_end_ff;
   logic [ColAW-1:0] col_addr_ff;
   pixel_type        pix_ff;
   pixel_type        leave_pix;
   logic [23:0]      leave_raw;
   logic [3*ColW-1:0] cs_rd, cs_new;
   logic [TotW-1:0]  tot [3];
   logic [ProdW-1:0] prod_ff [3];
   logic             rsp_valid_ff;
   pixel_type        rsp_data_ff;
   logic             rsp_last_ff;

   // effective geometry
   always_comb begin
      if (width_cfg_ff == 12'd0) begin
         width_eff = WidW'(1);
      end else if (32'(width_cfg_ff) > MAX_PADDED_WIDTH) begin
         width_eff = WidW'(MAX_PADDED_WIDTH);
      end else begin
         width_eff = WidW'(width_cfg_ff);
      end
      if (32'(radius_cfg_ff) > MAX_RADIUS) begin
         radius = RadW'(MAX_RADIUS);
      end else begin
         radius = RadW'(radius_cfg_ff);
      end
      span  = SpanW'({radius, 1'b1});
      two_r = SpanW'({radius, 1'b0});
   end

   // position of the incoming pixel
   always_comb begin
      col_a  = req_tuser ? '0 : col_ff;
      row_a  = req_tuser ? '0 : row_ff;
      slot_a = req_tuser ? '0 : slot_ff;
      if (32'(col_a) >= 32'(width_eff)) begin
         col_a = '0;
      end
      slot_x = (SpanW+1)'(slot_a);
      if (slot_x >= (SpanW+1)'(span)) begin
         leave_slot = SlotW'(slot_x - (SpanW+1)'(span));
      end else begin
         leave_slot = SlotW'(slot_x + (SpanW+1)'(Ring) - (SpanW+1)'(span));
      end
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (req_tvalid) state_in = ST_CALC;
         ST_CALC: state_in = ST_MUL;
         ST_MUL:  state_in = ST_EMIT;
         ST_EMIT: if (!rsp_valid_ff || rsp_tready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready = (state_ff == ST_IDLE);
      calc_en    = (state_ff == ST_CALC);
      mul_en     = (state_ff == ST_MUL);
      emit_go    = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_tready);
   end

   assign accept    = req_tvalid && req_tready;
   assign csr_ready = 1'b1;
   assign csr_wr    = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         width_cfg_ff  <= 12'd642;
         radius_cfg_ff <= 3'd1;
         col_ff        <= '0;
         row_ff        <= '0;
         slot_ff       <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_wr) begin
            case (csr_index)
               CSR_PADDED_WIDTH:  width_cfg_ff  <= csr_data;
               CSR_WINDOW_RADIUS: radius_cfg_ff <= csr_data[2:0];
               default: ;
            endcase
            col_ff  <= '0;
            row_ff  <= '0;
            slot_ff <= '0;
         end else if (accept) begin
            if (32'(col_a) + 1 >= 32'(width_eff)) begin
               col_ff  <= '0;
               row_ff  <= (32'(row_a) < SpanMax) ? row_a + SpanW'(1) : row_a;
               slot_ff <= (32'(slot_a) == Ring - 1) ? '0 : slot_a + SlotW'(1);
            end else begin
               col_ff  <= col_a + ColAW'(1);
               row_ff  <= row_a;
               slot_ff <= slot_a;
            end
         end
      end
   end

   // per-pixel context
   always_ff @(posedge clock) begin
      if (accept) begin
         pix_ff           <= req_tdata;
         col_addr_ff      <= col_a;
         ctrl_ff.row_zero <= (row_a == '0);
         ctrl_ff.row_full <= (row_a >= span);
         ctrl_ff.col_zero <= (col_a == '0);
         ctrl_ff.col_full <= (32'(col_a) >= 32'(span));
         produce_ff       <= (row_a >= two_r) && (32'(col_a) >= 32'(two_r));
         row_end_ff       <= (32'(col_a) + 1 == 32'(width_eff));
      end
   end

   bbf_ram #(
      .DataW (24),
      .AddrW (SlotW + ColAW)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr ({slot_a, col_a}),
      .wr_data (req_tdata),
      .rd_en   (accept),
      .rd_addr ({leave_slot, col_a}),
      .rd_data (leave_raw)
   );

   assign leave_pix = leave_raw;

   bbf_ram #(
      .DataW (3*ColW),
      .AddrW (ColAW)
   ) u_col_sums (
      .clock   (clock),
      .wr_en   (calc_en),
      .wr_addr (col_addr_ff),
      .wr_data (cs_new),
      .rd_en   (accept),
      .rd_addr (col_a),
      .rd_data (cs_rd)
   );

   bbf_window #(
      .MAX_RADIUS (MAX_RADIUS)
   ) u_window (
      .clock   (clock),
      .calc_en (calc_en),
      .ctrl    (ctrl_ff),
      .span    (span),
      .pix     (pix_ff),
      .leave   (leave_pix),
      .cs_rd   (cs_rd),
      .cs_new  (cs_new),
      .tot     (tot)
   );

   // divide by area as multiply by reciprocal
   always_ff @(posedge clock) begin
      if (mul_en) begin
         for (int c = 0; c < 3; c++) begin
            prod_ff[c] <= ProdW'(tot[c]) * ProdW'(RECIP_TABLE[4'(radius)]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit_go && produce_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit_go && produce_ff) begin
         rsp_data_ff.blue  <= prod_ff[0][RecipShift +: 8];
         rsp_data_ff.green <= prod_ff[1][RecipShift +: 8];
         rsp_data_ff.red   <= prod_ff[2][RecipShift +: 8];
         rsp_last_ff       <= row_end_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

@@ hw/rtl/bbf_ram.sv @@
// ----------------------------------------------------------------------------
// bbf_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module bbf_ram import bbf_pkg::*; #(
   parameter int DataW = 24,
   parameter int AddrW = 15
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AddrW-1:0] wr_addr,
   input  logic [DataW-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AddrW-1:0] rd_addr,
   output logic [DataW-1:0] rd_data
);

   logic [DataW-1:0] store_ff [1<<AddrW];
   logic [DataW-1:0] rd_data_ff;

   // read returns the old contents on a same-address write
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/bbf_window.sv @@
// ----------------------------------------------------------------------------
// bbf_window
// Column sum update and horizontal running window total per channel.
// ----------------------------------------------------------------------------
module bbf_window import bbf_pkg::*; #(
   parameter int  MAX_RADIUS = 7,
   localparam int SpanMax    = 2*MAX_RADIUS + 1,
   localparam int SpanW      = $clog2(SpanMax + 1),
   localparam int IdxW       = $clog2(SpanMax),
   localparam int ColW       = $clog2(255*SpanMax + 1),
   localparam int TotW       = $clog2(255*SpanMax*SpanMax + 1)
) (
   input  logic                  clock,
   input  logic                  calc_en,
   input  win_ctrl_type          ctrl,
   input  logic [SpanW-1:0]      span,
   input  pixel_type             pix,
   input  pixel_type             leave,
   input  logic [3*ColW-1:0]     cs_rd,
   output logic [3*ColW-1:0]     cs_new,
   output logic [TotW-1:0]       tot [3]
);

   logic [ColW-1:0] col_ff [SpanMax][3];
   logic [TotW-1:0] tot_ff [3];
   logic [TotW-1:0] tot_in [3];
   logic [ColW-1:0] cs_ch  [3];
   logic [7:0]      pix_ch [3];
   logic [7:0]      lv_ch  [3];
   logic [SpanW-1:0] sel_w;
   logic [IdxW-1:0]  sel;

   assign pix_ch[0] = pix.blue;
   assign pix_ch[1] = pix.green;
   assign pix_ch[2] = pix.red;
   assign lv_ch[0]  = leave.blue;
   assign lv_ch[1]  = leave.green;
   assign lv_ch[2]  = leave.red;

   assign sel_w = span - SpanW'(1);
   assign sel   = sel_w[IdxW-1:0];

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         cs_ch[c] = (ctrl.row_zero ? ColW'(0) : cs_rd[c*ColW +: ColW])
                  + ColW'(pix_ch[c])
                  - (ctrl.row_full ? ColW'(lv_ch[c]) : ColW'(0));
         cs_new[c*ColW +: ColW] = cs_ch[c];
         tot_in[c] = (ctrl.col_zero ? TotW'(0) : tot_ff[c])
                   + TotW'(cs_ch[c])
                   - (ctrl.col_full ? TotW'(col_ff[sel][c]) : TotW'(0));
      end
   end

   // col_ff[k] holds the column sum k+1 columns back
   always_ff @(posedge clock) begin
      if (calc_en) begin
         for (int c = 0; c < 3; c++) begin
            tot_ff[c]    <= tot_in[c];
            col_ff[0][c] <= cs_ch[c];
            for (int k = 1; k < SpanMax; k++) begin
               col_ff[k][c] <= col_ff[k-1][c];
            end
         end
      end
   end

   assign tot = tot_ff;

endmodule

@@ hw/rtl/bbf_checker.sv @@
// ----------------------------------------------------------------------------
// bbf_checker
// Port-level checks for the RGB box blur filter, bound to the top level.
// ----------------------------------------------------------------------------
module bbf_props import bbf_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata,
   input logic        rsp_tlast
);

   // a stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped while stalled");

   // and keeps its payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled result changed");

   // one pixel at a time: busy right after a transfer
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input taken while busy");

   // reset drops any pending result
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind rgb_box_blur_filter bbf_props u_bbf_props (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
